// ----- hdl/lpht_pkg.sv -----
// shared types and constants for the linear probing hash table
`default_nettype none

package lpht_pkg;

  localparam int KEY_W          = 64;
  localparam int VAL_W          = 31;
  localparam int STATUS_W       = 3;
  localparam int COUNT_W        = 11;
  localparam int OP_W           = 2;
  localparam int CFG_W          = 4;
  localparam int HASH_W         = 16;
  localparam int MIN_SLOTS_LOG2 = 4;
  localparam int MIX_SHIFT      = 33;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd5;

  localparam logic [KEY_W-1:0] RESERVED_KEY = 64'hffff_ffff_ffff_ffff;
  localparam logic [KEY_W-1:0] MIX_C1       = 64'hff51_afd7_ed55_8ccd;
  localparam logic [KEY_W-1:0] MIX_C2       = 64'hc4ce_b9fe_1a85_ec53;

  // what the back end has to do with a queued item
  typedef enum logic [2:0] {
    CLS_LOOKUP,
    CLS_INSERT,
    CLS_CLEAR,
    CLS_RESERVED,
    CLS_NOP
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [HASH_W-1:0] home;
  } item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_PUSH
  } front_st_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_SWEEP
  } back_st_t;

endpackage

`default_nettype wire

// ----- hdl/lpht_front.sv -----
// front end: accepts beats, classifies them and computes the 64-bit hash mix
`default_nettype none

module lpht_front (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             hold,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [lpht_pkg::OP_W-1:0]       in_operation,
  input  wire  [lpht_pkg::KEY_W-1:0]      in_key,
  input  wire  [lpht_pkg::VAL_W-1:0]      in_value,
  output logic                            push_valid,
  input  wire                             push_ready,
  output lpht_pkg::item_t                 push_item
);
  import lpht_pkg::*;

  front_st_t        st_r, st_nxt;
  item_t            item_r, item_nxt;
  logic [KEY_W-1:0] x_r, x_nxt;
  logic             round_r, round_nxt;
  logic [63:0]      pp_ll_r;
  logic [31:0]      pp_hl_r, pp_lh_r;
  logic [63:0]      pp_ll;
  logic [31:0]      pp_hl, pp_lh;
  logic [KEY_W-1:0] mix_c, prod;
  logic             accept;
  cls_t             cls_in;

  function automatic logic [KEY_W-1:0] xorshift(input logic [KEY_W-1:0] v);
    xorshift = v ^ (v >> MIX_SHIFT);
  endfunction

  // three 32x32 partial products of the low 64 bits of x * c
  assign mix_c = round_r ? MIX_C2 : MIX_C1;
  assign pp_ll = 64'(x_r[31:0]) * 64'(mix_c[31:0]);
  assign pp_hl = x_r[63:32] * mix_c[31:0];
  assign pp_lh = x_r[31:0] * mix_c[63:32];
  assign prod  = pp_ll_r + {pp_hl_r + pp_lh_r, 32'b0};

  always_comb begin
    unique case (in_operation)
      OP_LOOKUP: cls_in = (in_key == RESERVED_KEY) ? CLS_RESERVED : CLS_LOOKUP;
      OP_INSERT: cls_in = (in_key == RESERVED_KEY) ? CLS_RESERVED : CLS_INSERT;
      OP_CLEAR:  cls_in = CLS_CLEAR;
      default:   cls_in = CLS_NOP;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    item_nxt   = item_r;
    x_nxt      = x_r;
    round_nxt  = round_r;
    in_ready   = !hold && ((st_r == F_IDLE) || ((st_r == F_PUSH) && push_ready));
    accept     = in_valid && in_ready;
    push_valid = (st_r == F_PUSH);
    push_item  = item_r;
    unique case (st_r)
      F_IDLE: st_nxt = F_IDLE;
      F_MUL:  st_nxt = F_SUM;
      F_SUM: begin
        x_nxt     = xorshift(prod);
        round_nxt = !round_r;
        if (round_r) begin
          item_nxt.home = x_nxt[HASH_W-1:0];
          st_nxt        = F_PUSH;
        end else begin
          st_nxt = F_MUL;
        end
      end
      F_PUSH: if (push_ready) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
    if (accept) begin
      item_nxt.cls   = cls_in;
      item_nxt.key   = in_key;
      item_nxt.value = in_value;
      item_nxt.home  = '0;
      x_nxt          = xorshift(in_key);
      round_nxt      = 1'b0;
      st_nxt         = ((cls_in == CLS_LOOKUP) || (cls_in == CLS_INSERT)) ? F_MUL : F_PUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= F_IDLE;
      round_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    x_r    <= x_nxt;
    if (st_r == F_MUL) begin
      pp_ll_r <= pp_ll;
      pp_hl_r <= pp_hl;
      pp_lh_r <= pp_lh;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lpht_queue.sv -----
// two-entry queue between the front end and the probe engine
`default_nettype none

module lpht_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push_valid,
  output logic                  push_ready,
  input  wire lpht_pkg::item_t  push_item,
  output logic                  pop_valid,
  input  wire                   pop_ready,
  output lpht_pkg::item_t       pop_item
);
  import lpht_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);
  localparam logic [PW:0] FULL_CNT = (PW + 1)'(QDEPTH);

  item_t         q_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_item;
  end

endmodule

`default_nettype wire

// ----- hdl/lpht_back.sv -----
// probe engine: slot memories, linear probe walk, clear sweep and result register
`default_nettype none

module lpht_back #(
  parameter int MAX_SLOTS_LOG2 = 10
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              pop_valid,
  output logic                             pop_ready,
  input  wire lpht_pkg::item_t             pop_item,
  input  wire  [lpht_pkg::CFG_W-1:0]       slots_log2,
  output logic                             sweeping,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]    out_status,
  output logic [lpht_pkg::VAL_W-1:0]       out_found_value,
  output logic [lpht_pkg::COUNT_W-1:0]     out_entry_count
);
  import lpht_pkg::*;

  localparam int AW    = MAX_SLOTS_LOG2;
  localparam int DEPTH = 1 << AW;
  localparam int CNT_W = AW + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [4:0] MIN_L = 5'(MIN_SLOTS_LOG2);
  localparam logic [4:0] MAX_L = 5'(MAX_SLOTS_LOG2);

  logic [KEY_W-1:0] key_mem  [DEPTH];
  logic [VAL_W-1:0] val_mem  [DEPTH];
  logic             used_mem [DEPTH];
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic             rd_used_r;

  back_st_t         st_r, st_nxt;
  cls_t             cls_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    probes_r, probes_nxt;
  logic [AW-1:0]    clr_idx_r, clr_idx_nxt;
  logic             reply_r, reply_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_found_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [4:0]          live;
  logic [AW:0]         span;
  logic [AW-1:0]       mask;
  logic                out_free, pop_fire;
  logic [AW-1:0]       rd_addr, used_addr;
  logic                used_we, used_wd, key_we, val_we;
  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    res_found;

  // slots in use, saturated to the supported range
  always_comb begin
    if ({1'b0, slots_log2} < MIN_L)      live = MIN_L;
    else if ({1'b0, slots_log2} > MAX_L) live = MAX_L;
    else                                 live = {1'b0, slots_log2};
  end
  assign span = {{AW{1'b0}}, 1'b1} << live;
  assign mask = AW'(span - 1'b1);

  assign out_free = !out_valid_r || out_ready;
  assign pop_fire = pop_valid && pop_ready;

  always_comb begin
    st_nxt      = st_r;
    idx_nxt     = idx_r;
    probes_nxt  = probes_r;
    clr_idx_nxt = clr_idx_r;
    reply_nxt   = reply_r;
    count_nxt   = count_r;
    pop_ready   = 1'b0;
    rd_addr     = idx_r;
    used_addr   = idx_r;
    used_we     = 1'b0;
    used_wd     = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    res_load    = 1'b0;
    res_status  = ST_MISS;
    res_found   = '0;
    sweeping    = (st_r == B_SWEEP) && !reply_r;
    unique case (st_r)
      B_IDLE: begin
        pop_ready = out_free;
        if (pop_valid && out_free) begin
          unique case (pop_item.cls) inside
            CLS_LOOKUP, CLS_INSERT: begin
              rd_addr    = pop_item.home[AW-1:0] & mask;
              idx_nxt    = rd_addr;
              probes_nxt = '0;
              st_nxt     = B_CHECK;
            end
            CLS_CLEAR: begin
              count_nxt   = '0;
              clr_idx_nxt = '0;
              reply_nxt   = 1'b1;
              st_nxt      = B_SWEEP;
            end
            CLS_RESERVED: begin
              res_load   = 1'b1;
              res_status = ST_RESERVED;
            end
            default: begin
              res_load   = 1'b1;
              res_status = ST_MISS;
            end
          endcase
        end
      end
      B_CHECK: begin
        if (!rd_used_r) begin
          res_load = 1'b1;
          st_nxt   = B_IDLE;
          if (cls_r == CLS_INSERT) begin
            key_we     = 1'b1;
            val_we     = 1'b1;
            used_we    = 1'b1;
            used_wd    = 1'b1;
            count_nxt  = count_r + 1'b1;
            res_status = ST_INSERTED;
          end else begin
            res_status = ST_MISS;
          end
        end else if (rd_key_r == key_r) begin
          res_load = 1'b1;
          st_nxt   = B_IDLE;
          if (cls_r == CLS_INSERT) begin
            val_we     = 1'b1;
            res_status = ST_UPDATED;
          end else begin
            res_status = ST_HIT;
            res_found  = rd_val_r;
          end
        end else if (probes_r == mask) begin
          res_load   = 1'b1;
          st_nxt     = B_IDLE;
          res_status = (cls_r == CLS_INSERT) ? ST_FULL : ST_MISS;
        end else begin
          probes_nxt = probes_r + 1'b1;
          rd_addr    = (idx_r + 1'b1) & mask;
          idx_nxt    = rd_addr;
        end
      end
      B_SWEEP: begin
        used_we     = 1'b1;
        used_addr   = clr_idx_r;
        used_wd     = 1'b0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          st_nxt    = B_IDLE;
          reply_nxt = 1'b0;
          if (reply_r) begin
            res_load   = 1'b1;
            res_status = ST_HIT;
          end
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_SWEEP;
      clr_idx_r   <= '0;
      reply_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_idx_r <= clr_idx_nxt;
      reply_r   <= reply_nxt;
      count_r   <= count_nxt;
      if (res_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    probes_r <= probes_nxt;
    if (pop_fire) begin
      cls_r <= pop_item.cls;
      key_r <= pop_item.key;
      val_r <= pop_item.value;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[idx_r] <= key_r;
    rd_key_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[idx_r] <= val_r;
    rd_val_r <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_addr] <= used_wd;
    rd_used_r <= used_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_entry_count = out_count_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> out_free)
    else $error("result register overwritten before it was taken");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("entry count above slot depth");

  a_sweep_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SWEEP) |-> !pop_fire)
    else $error("queue popped during clear sweep");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (res_status != ST_HIT)) |=> (out_found_value == '0))
    else $error("found value not zero on a result other than hit");

endmodule

`default_nettype wire

// ----- hdl/linear_probe_hash_table.sv -----
// top level of the linear probing hash table with its slot-count register
//
//  channel  direction  beat contents                          handshake
//  in       sink       in_operation, in_key, in_value         in_valid / in_ready
//  out      source     out_status, out_found_value,           out_valid / out_ready
//                      out_entry_count
//  cfg      sink       cfg_data (slots_log2)                  cfg_we, no wait
//
//  front end takes a lookup or insert through accept, two rounds of
//  partial-product multiply and sum for the hash mix, then the queue push
//  probe engine reads the slot memories once per probe, and a short walk
//  keeps pace with the front end
//  clear sweeps all 2**MAX_SLOTS_LOG2 used bits, then answers
//  after reset the same sweep runs and in_ready stays low for its length
//  a two-entry queue and the result register let either side stall alone
`default_nettype none

module linear_probe_hash_table #(
  parameter int MAX_SLOTS_LOG2 = 10
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [lpht_pkg::OP_W-1:0]        in_operation,
  input  wire  [lpht_pkg::KEY_W-1:0]       in_key,
  input  wire  [lpht_pkg::VAL_W-1:0]       in_value,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]    out_status,
  output logic [lpht_pkg::VAL_W-1:0]       out_found_value,
  output logic [lpht_pkg::COUNT_W-1:0]     out_entry_count,
  input  wire                              cfg_we,
  input  wire  [lpht_pkg::CFG_W-1:0]       cfg_data
);
  import lpht_pkg::*;

  // slot count register; the user must write it only while the block is idle, the block does not enforce it
  logic [CFG_W-1:0] slots_log2_r;

  // front end to queue
  logic  push_valid, push_ready;
  item_t push_item;

  // queue to probe engine
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // high while the reset sweep runs, holds off new beats
  logic  sweeping;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_log2_r <= CFG_RESET;
    end else if (cfg_we) begin
      slots_log2_r <= cfg_data;
    end
  end

  // classify and hash
  lpht_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (sweeping),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_value     (in_value),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  // decouples hashing from probing
  lpht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // probe walk over the slot memories
  lpht_back #(
    .MAX_SLOTS_LOG2 (MAX_SLOTS_LOG2)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .slots_log2      (slots_log2_r),
    .sweeping        (sweeping),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire
